// File: hdl/ppba_pkg.sv
// ----------------------------------------------------------------------------
// ppba_pkg: shared definitions for the pulse peak BPM averager
// Widths, register indexes, reset values, divider constants, the sequencer
// state type and the divider request and response structs.
// ----------------------------------------------------------------------------
package ppba_pkg;

   // Field widths.
   localparam int unsigned SAMPLE_W  = 10;
   localparam int unsigned PERIOD_W  = 10;
   localparam int unsigned TIME_W    = 16;
   localparam int unsigned RATE_W    = 8;
   localparam int unsigned SCALE_W   = 10;
   localparam int unsigned HYST_W    = 12;
   localparam int unsigned LEVEL_W   = 20;
   localparam int unsigned PEAK_W    = 21;
   localparam int unsigned CSR_IDX_W = 2;
   localparam int unsigned CSR_DAT_W = 16;

   localparam int unsigned HISTORY_DEPTH_DEF = 8;

   // Configuration register indexes.
   localparam logic [CSR_IDX_W-1:0] CSR_PERIOD  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_TIMEOUT = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_MIN_BPM = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_MAX_BPM = 2'd3;

   // Configuration reset values.
   localparam logic [PERIOD_W-1:0] PERIOD_RST  = 10'd60;
   localparam logic [TIME_W-1:0]   TIMEOUT_RST = 16'd7000;
   localparam logic [RATE_W-1:0]   MIN_BPM_RST = 8'd40;
   localparam logic [RATE_W-1:0]   MAX_BPM_RST = 8'd200;

   // Shared divider: dividends are left aligned so that only the
   // significant bits are stepped through.
   localparam int unsigned DIV_W     = 16;
   localparam int unsigned DIV_CNT_W = 5;

   localparam int unsigned SCALE_STEPS = 10;
   localparam int unsigned HYST_STEPS  = 12;
   localparam int unsigned BPM_STEPS   = 16;

   localparam logic [DIV_W-1:0] SCALE_DVD = DIV_W'(1000 << (DIV_W - SCALE_STEPS));
   localparam logic [DIV_W-1:0] HYST_DVD  = DIV_W'(3000 << (DIV_W - HYST_STEPS));
   localparam logic [DIV_W-1:0] BPM_DVD   = DIV_W'(60000);

   // floor(x / 5) = (x * RECIP5) >> RECIP5_SHIFT for x below 2**22.
   localparam int unsigned       RECIP5_SHIFT = 26;
   localparam logic [23:0]       RECIP5       = 24'd13421773;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_SCALE,
      ST_HYST,
      ST_MUL,
      ST_DECAY,
      ST_PEAK,
      ST_RATE,
      ST_PUSH,
      ST_MEAN_GO,
      ST_MEAN,
      ST_FINISH
   } state_type;

   typedef struct packed {
      logic                 start;
      logic [DIV_W-1:0]     dividend;
      logic [DIV_W-1:0]     divisor;
      logic [DIV_CNT_W-1:0] steps;
   } div_req_type;

   typedef struct packed {
      logic             done;
      logic [DIV_W-1:0] quotient;
   } div_rsp_type;

endpackage

// File: hdl/ppba_if.sv
// ----------------------------------------------------------------------------
// ppba_if: request and response channels of the pulse peak BPM averager
// Valid/ready channels; a request moves on an edge where both are high.
// ----------------------------------------------------------------------------
interface ppba_req_if import ppba_pkg::*; ();
   logic                valid;
   logic                ready;
   logic [SAMPLE_W-1:0] adc_sample;

   modport source (output valid, output adc_sample, input ready);
   modport sink   (input valid, input adc_sample, output ready);
endinterface

interface ppba_rsp_if import ppba_pkg::*; ();
   logic              valid;
   logic              ready;
   logic              beat_detected;
   logic              new_bpm_accepted;
   logic [RATE_W-1:0] average_bpm;
   logic              history_cleared;

   modport source (output valid, output beat_detected, output new_bpm_accepted,
                   output average_bpm, output history_cleared, input ready);
   modport sink   (input valid, input beat_detected, input new_bpm_accepted,
                   input average_bpm, input history_cleared, output ready);
endinterface

// File: hdl/pulse_peak_bpm_averager.sv
// ----------------------------------------------------------------------------
// pulse_peak_bpm_averager: beat detector and BPM averager for a pulse sensor
// Each request is one sensor sample; each produces exactly one response
// carrying the beat flag, the accepted flag, the running average and the
// timeout-cleared flag.
//
// Usage: one request on req_bus per sample tick; the response comes out on
// rsp_bus. Registers sample_period_ms, timeout_ms, min_bpm and max_bpm are
// written through csr_we/csr_index/csr_wdata while no request is in flight.
// A single sequencer drives one shared restoring divider and handles one
// request at a time; req_bus.ready is low while it works. The divider runs
// the scale and hysteresis divisions for every request, the rate division
// for a beat with a nonzero interval, and the mean division for a rate
// that enters the history.
// The response is held in an output register, so a stalled receiver does
// not block the next request; the sequencer waits only if the previous
// response is still unclaimed when the next one is ready.
// Reset (synchronous) restores the register defaults and clears the peak
// tracker, the interval timers, the history and the average.
// ----------------------------------------------------------------------------
module pulse_peak_bpm_averager import ppba_pkg::*; #(
   parameter int unsigned HISTORY_DEPTH = HISTORY_DEPTH_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   ppba_req_if.sink             req_bus,
   ppba_rsp_if.source           rsp_bus,
   input  logic                 csr_we,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [CSR_DAT_W-1:0] csr_wdata
);

   localparam int unsigned FILL_W = $clog2(HISTORY_DEPTH + 1);
   localparam int unsigned SUM_W  = $clog2(HISTORY_DEPTH * 255 + 1);

   state_type state_ff, state_in;

   // Configuration.
   logic [PERIOD_W-1:0] period_ff, period_in;
   logic [TIME_W-1:0]   timeout_ff, timeout_in;
   logic [RATE_W-1:0]   min_bpm_ff, min_bpm_in;
   logic [RATE_W-1:0]   max_bpm_ff, max_bpm_in;
   logic [PERIOD_W-1:0] period_eff;

   // Tracker and history state.
   logic [PEAK_W-1:0]   peak_ff, peak_in;
   logic                in_peak_ff, in_peak_in;
   logic [TIME_W-1:0]   interval_ff, interval_in;
   logic [TIME_W-1:0]   since_ff, since_in;
   logic [RATE_W-1:0]   hist_ff [HISTORY_DEPTH];
   logic [RATE_W-1:0]   hist_in [HISTORY_DEPTH];
   logic [FILL_W-1:0]   filled_ff, filled_in;
   logic [SUM_W-1:0]    sum_ff, sum_in;
   logic [RATE_W-1:0]   mean_ff, mean_in;

   // Per-request working registers.
   logic [SAMPLE_W-1:0] sample_ff, sample_in;
   logic [SCALE_W-1:0]  scale_ff, scale_in;
   logic [HYST_W-1:0]   hyst_ff, hyst_in;
   logic [LEVEL_W-1:0]  level_ff, level_in;
   logic [RATE_W-1:0]   rate_ff, rate_in;
   logic                beat_ff, beat_in;
   logic                accepted_ff, accepted_in;
   logic                cleared_ff, cleared_in;

   // Response register.
   logic                rsp_valid_ff, rsp_valid_in;
   logic                rsp_beat_ff, rsp_beat_in;
   logic                rsp_accepted_ff, rsp_accepted_in;
   logic [RATE_W-1:0]   rsp_mean_ff, rsp_mean_in;
   logic                rsp_cleared_ff, rsp_cleared_in;
   logic                rsp_free;

   div_req_type div_req;
   div_rsp_type div_rsp;

   // Peak evaluation terms.
   logic [LEVEL_W+1:0]  level_x4;
   logic [45:0]         decay_prod;
   logic [LEVEL_W-1:0]  decay_level;
   logic                above_band;
   logic                below_band;
   logic                pk_beat;
   logic                rate_go;
   logic [TIME_W:0]     since_sum;
   logic [TIME_W-1:0]   since_sat;
   logic [TIME_W:0]     interval_sum;
   logic                in_window;

   ppba_div u_div (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

   assign period_eff  = (period_ff == '0) ? PERIOD_W'(1) : period_ff;
   assign rsp_free    = !rsp_valid_ff || rsp_bus.ready;

   assign level_x4    = {level_ff, 2'b00};
   assign decay_prod  = level_x4 * RECIP5;
   assign decay_level = decay_prod[RECIP5_SHIFT +: LEVEL_W];

   assign above_band  = (PEAK_W'(level_ff) + PEAK_W'(scale_ff)) > peak_ff;
   assign below_band  = (PEAK_W'(level_ff) + PEAK_W'(hyst_ff)) < peak_ff;
   assign pk_beat     = above_band && !in_peak_ff;
   assign rate_go     = pk_beat && (interval_ff != '0);

   assign since_sum    = {1'b0, since_ff} + (TIME_W + 1)'(period_eff);
   assign since_sat    = since_sum[TIME_W] ? '1 : since_sum[TIME_W-1:0];
   assign interval_sum = {1'b0, interval_ff} + (TIME_W + 1)'(period_eff);

   assign in_window = (div_rsp.quotient >= DIV_W'(min_bpm_ff)) &&
                      (div_rsp.quotient <= DIV_W'(max_bpm_ff));

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE:    if (req_bus.valid) state_in = ST_SCALE;
         ST_SCALE:   if (div_rsp.done) state_in = ST_HYST;
         ST_HYST:    if (div_rsp.done) state_in = ST_MUL;
         ST_MUL:     state_in = ST_DECAY;
         ST_DECAY:   state_in = ST_PEAK;
         ST_PEAK:    state_in = rate_go ? ST_RATE : ST_FINISH;
         ST_RATE: begin
            if (div_rsp.done) state_in = in_window ? ST_PUSH : ST_FINISH;
         end
         ST_PUSH:    state_in = ST_MEAN_GO;
         ST_MEAN_GO: state_in = ST_MEAN;
         ST_MEAN:    if (div_rsp.done) state_in = ST_FINISH;
         ST_FINISH:  if (rsp_free) state_in = ST_IDLE;
         default:    state_in = ST_IDLE;
      endcase
   end

   // Sequencer outputs: request handshake and divider launches.
   always_comb begin
      req_bus.ready = 1'b0;
      div_req       = '0;
      unique case (state_ff)
         ST_IDLE: begin
            req_bus.ready    = 1'b1;
            div_req.start    = req_bus.valid;
            div_req.dividend = SCALE_DVD;
            div_req.divisor  = DIV_W'(period_eff);
            div_req.steps    = DIV_CNT_W'(SCALE_STEPS);
         end
         ST_SCALE: begin
            div_req.start    = div_rsp.done;
            div_req.dividend = HYST_DVD;
            div_req.divisor  = DIV_W'(period_eff);
            div_req.steps    = DIV_CNT_W'(HYST_STEPS);
         end
         ST_PEAK: begin
            // The rate uses the interval as it stood before this beat.
            div_req.start    = rate_go;
            div_req.dividend = BPM_DVD;
            div_req.divisor  = interval_ff;
            div_req.steps    = DIV_CNT_W'(BPM_STEPS);
         end
         ST_MEAN_GO: begin
            div_req.start    = 1'b1;
            div_req.dividend = DIV_W'(sum_ff) << (DIV_W - SUM_W);
            div_req.divisor  = DIV_W'(filled_ff);
            div_req.steps    = DIV_CNT_W'(SUM_W);
         end
         default: begin
            div_req = '0;
         end
      endcase
   end

   // Configuration writes.
   always_comb begin
      period_in  = period_ff;
      timeout_in = timeout_ff;
      min_bpm_in = min_bpm_ff;
      max_bpm_in = max_bpm_ff;
      if (csr_we) begin
         unique case (csr_index)
            CSR_PERIOD:  period_in  = csr_wdata[PERIOD_W-1:0];
            CSR_TIMEOUT: timeout_in = csr_wdata[TIME_W-1:0];
            CSR_MIN_BPM: min_bpm_in = csr_wdata[RATE_W-1:0];
            CSR_MAX_BPM: max_bpm_in = csr_wdata[RATE_W-1:0];
            default:     period_in  = period_ff;
         endcase
      end
   end

   // Datapath.
   always_comb begin
      peak_in     = peak_ff;
      in_peak_in  = in_peak_ff;
      interval_in = interval_ff;
      since_in    = since_ff;
      hist_in     = hist_ff;
      filled_in   = filled_ff;
      sum_in      = sum_ff;
      mean_in     = mean_ff;
      sample_in   = sample_ff;
      scale_in    = scale_ff;
      hyst_in     = hyst_ff;
      level_in    = level_ff;
      rate_in     = rate_ff;
      beat_in     = beat_ff;
      accepted_in = accepted_ff;
      cleared_in  = cleared_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_bus.valid) begin
               sample_in   = req_bus.adc_sample;
               beat_in     = 1'b0;
               accepted_in = 1'b0;
               cleared_in  = 1'b0;
            end
         end
         ST_SCALE: begin
            if (div_rsp.done) scale_in = div_rsp.quotient[SCALE_W-1:0];
         end
         ST_HYST: begin
            if (div_rsp.done) hyst_in = div_rsp.quotient[HYST_W-1:0];
         end
         ST_MUL: begin
            level_in = LEVEL_W'(sample_ff) * LEVEL_W'(scale_ff);
         end
         ST_DECAY: begin
            // The tracked peak decays to four fifths of the level when the
            // signal has fallen far below it.
            if ((PEAK_W + 1)'(level_x4) < (PEAK_W + 1)'(peak_ff)) begin
               peak_in = PEAK_W'(decay_level);
            end
         end
         ST_PEAK: begin
            if (above_band) begin
               if (PEAK_W'(level_ff) > peak_ff) peak_in = PEAK_W'(level_ff);
               in_peak_in = 1'b1;
            end else if (below_band) begin
               in_peak_in = 1'b0;
               peak_in    = peak_ff - PEAK_W'(scale_ff);
            end
            beat_in = pk_beat;
            if (pk_beat) begin
               interval_in = TIME_W'(period_eff);
               since_in    = '0;
            end else begin
               interval_in = interval_sum[TIME_W] ? '1 : interval_sum[TIME_W-1:0];
               since_in    = since_sat;
               if (since_sat > timeout_ff) begin
                  for (int i = 0; i < HISTORY_DEPTH; i++) hist_in[i] = '0;
                  filled_in  = '0;
                  sum_in     = '0;
                  mean_in    = '0;
                  cleared_in = 1'b1;
               end
            end
         end
         ST_RATE: begin
            if (div_rsp.done && in_window) begin
               rate_in     = div_rsp.quotient[RATE_W-1:0];
               accepted_in = 1'b1;
            end
         end
         ST_PUSH: begin
            for (int i = HISTORY_DEPTH - 1; i > 0; i--) hist_in[i] = hist_ff[i-1];
            hist_in[0] = rate_ff;
            // The running sum drops the entry shifted out of the oldest slot.
            sum_in = sum_ff + SUM_W'(rate_ff) - SUM_W'(hist_ff[HISTORY_DEPTH-1]);
            if (filled_ff != FILL_W'(HISTORY_DEPTH)) filled_in = filled_ff + FILL_W'(1);
         end
         ST_MEAN: begin
            if (div_rsp.done) mean_in = div_rsp.quotient[RATE_W-1:0];
         end
         default: begin
            mean_in = mean_ff;
         end
      endcase
   end

   // Response register.
   always_comb begin
      rsp_valid_in    = rsp_valid_ff;
      rsp_beat_in     = rsp_beat_ff;
      rsp_accepted_in = rsp_accepted_ff;
      rsp_mean_in     = rsp_mean_ff;
      rsp_cleared_in  = rsp_cleared_ff;
      if (rsp_valid_ff && rsp_bus.ready) rsp_valid_in = 1'b0;
      if (state_ff == ST_FINISH && rsp_free) begin
         rsp_valid_in    = 1'b1;
         rsp_beat_in     = beat_ff;
         rsp_accepted_in = accepted_ff;
         rsp_mean_in     = mean_ff;
         rsp_cleared_in  = cleared_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         period_ff    <= PERIOD_RST;
         timeout_ff   <= TIMEOUT_RST;
         min_bpm_ff   <= MIN_BPM_RST;
         max_bpm_ff   <= MAX_BPM_RST;
         peak_ff      <= '0;
         in_peak_ff   <= 1'b0;
         interval_ff  <= '0;
         since_ff     <= '0;
         for (int i = 0; i < HISTORY_DEPTH; i++) hist_ff[i] <= '0;
         filled_ff    <= '0;
         sum_ff       <= '0;
         mean_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         period_ff    <= period_in;
         timeout_ff   <= timeout_in;
         min_bpm_ff   <= min_bpm_in;
         max_bpm_ff   <= max_bpm_in;
         peak_ff      <= peak_in;
         in_peak_ff   <= in_peak_in;
         interval_ff  <= interval_in;
         since_ff     <= since_in;
         hist_ff      <= hist_in;
         filled_ff    <= filled_in;
         sum_ff       <= sum_in;
         mean_ff      <= mean_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      sample_ff       <= sample_in;
      scale_ff        <= scale_in;
      hyst_ff         <= hyst_in;
      level_ff        <= level_in;
      rate_ff         <= rate_in;
      beat_ff         <= beat_in;
      accepted_ff     <= accepted_in;
      cleared_ff      <= cleared_in;
      rsp_beat_ff     <= rsp_beat_in;
      rsp_accepted_ff <= rsp_accepted_in;
      rsp_mean_ff     <= rsp_mean_in;
      rsp_cleared_ff  <= rsp_cleared_in;
   end

   assign rsp_bus.valid            = rsp_valid_ff;
   assign rsp_bus.beat_detected    = rsp_beat_ff;
   assign rsp_bus.new_bpm_accepted = rsp_accepted_ff;
   assign rsp_bus.average_bpm      = rsp_mean_ff;
   assign rsp_bus.history_cleared  = rsp_cleared_ff;

endmodule

// File: hdl/ppba_div.sv
// ----------------------------------------------------------------------------
// ppba_div: shared restoring divider
// One quotient bit per cycle over a left aligned dividend; done pulses for
// one cycle together with the final quotient.
// ----------------------------------------------------------------------------
module ppba_div import ppba_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  div_req_type div_req,
   output div_rsp_type div_rsp
);

   logic [DIV_W-1:0]     dvd_ff, dvd_in;
   logic [DIV_W-1:0]     rem_ff, rem_in;
   logic [DIV_W-1:0]     dvs_ff, dvs_in;
   logic [DIV_CNT_W-1:0] cnt_ff, cnt_in;
   logic                 done_ff, done_in;
   logic [DIV_W:0]       trial;
   logic [DIV_W:0]       diff;

   assign trial = {rem_ff, dvd_ff[DIV_W-1]};
   assign diff  = trial - {1'b0, dvs_ff};

   always_comb begin
      dvd_in  = dvd_ff;
      rem_in  = rem_ff;
      dvs_in  = dvs_ff;
      cnt_in  = cnt_ff;
      done_in = 1'b0;
      if (div_req.start) begin
         dvd_in = div_req.dividend;
         rem_in = '0;
         dvs_in = div_req.divisor;
         cnt_in = div_req.steps;
      end else if (cnt_ff != '0) begin
         // A borrow out of the trial subtraction means the bit is zero.
         if (!diff[DIV_W]) begin
            rem_in = diff[DIV_W-1:0];
         end else begin
            rem_in = trial[DIV_W-1:0];
         end
         dvd_in  = {dvd_ff[DIV_W-2:0], ~diff[DIV_W]};
         cnt_in  = cnt_ff - DIV_CNT_W'(1);
         done_in = (cnt_ff == DIV_CNT_W'(1));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff  <= '0;
         done_ff <= 1'b0;
      end else begin
         cnt_ff  <= cnt_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      dvd_ff <= dvd_in;
      rem_ff <= rem_in;
      dvs_ff <= dvs_in;
   end

   assign div_rsp.done     = done_ff;
   assign div_rsp.quotient = dvd_ff;

endmodule

// File: hdl/ppba_checker.sv
// ----------------------------------------------------------------------------
// ppba_checker: port-level checks for the pulse peak BPM averager
// Watches the request and response channels and flags impossible responses.
// ----------------------------------------------------------------------------
module ppba_checker import ppba_pkg::*; (
   input logic              clock,
   input logic              reset,
   input logic              req_valid,
   input logic              req_ready,
   input logic              rsp_valid,
   input logic              rsp_ready,
   input logic              rsp_beat,
   input logic              rsp_accepted,
   input logic [RATE_W-1:0] rsp_average,
   input logic              rsp_cleared
);

   // No response is pending right after reset.
   assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("response valid right after reset");

   // A stalled response keeps its contents.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid &&
         $stable({rsp_beat, rsp_accepted, rsp_average, rsp_cleared}))
      else $error("stalled response changed");

   // A rate can only enter the history on a beat.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_accepted |-> rsp_beat)
      else $error("rate accepted without a beat");

   // A timeout clear happens only without a beat and leaves a zero average.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_cleared |-> !rsp_beat && rsp_average == '0)
      else $error("history clear with beat or nonzero average");

   // The block works on one request at a time.
   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request accepted while the previous one is in work");

endmodule

bind pulse_peak_bpm_averager ppba_checker u_ppba_checker (
   .clock        (clock),
   .reset        (reset),
   .req_valid    (req_bus.valid),
   .req_ready    (req_bus.ready),
   .rsp_valid    (rsp_bus.valid),
   .rsp_ready    (rsp_bus.ready),
   .rsp_beat     (rsp_bus.beat_detected),
   .rsp_accepted (rsp_bus.new_bpm_accepted),
   .rsp_average  (rsp_bus.average_bpm),
   .rsp_cleared  (rsp_bus.history_cleared)
);

// File: tb/tb_pulse_peak_bpm_averager.sv
// ----------------------------------------------------------------------------
// tb_pulse_peak_bpm_averager: self-checking bench for the pulse BPM averager
// Drives sample requests through a valid/ready channel, predicts each
// response with a cycle-free model of the peak tracker, the interval timers
// and the rate history, and compares every response field by field. The run
// steps through several register settings and idling patterns, including a
// long receiver stall that backs the block up.
// ----------------------------------------------------------------------------
module tb_pulse_peak_bpm_averager import ppba_pkg::*; ();

   localparam int unsigned HIST_DEPTH    = HISTORY_DEPTH_DEF;
   localparam int unsigned SETTLE_CYCLES = 64;
   localparam int unsigned PHASE_ITEMS   = 120;
   localparam int unsigned CYCLE_LIMIT   = 1000000;
   localparam int unsigned REPORT_CAP    = 50;

   typedef struct {
      logic              beat;
      logic              accepted;
      logic [RATE_W-1:0] average;
      logic              cleared;
   } beat_outcome_type;

   logic                 clock;
   logic                 reset;
   logic                 csr_we;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [CSR_DAT_W-1:0] csr_wdata;

   ppba_req_if req_if ();
   ppba_rsp_if rsp_if ();

   pulse_peak_bpm_averager DUT (
      .clock     (clock),
      .reset     (reset),
      .req_bus   (req_if),
      .rsp_bus   (rsp_if),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   // Register copies used by the predictor.
   logic [PERIOD_W-1:0] period_cfg  = PERIOD_RST;
   logic [TIME_W-1:0]   timeout_cfg = TIMEOUT_RST;
   logic [RATE_W-1:0]   min_bpm_cfg = MIN_BPM_RST;
   logic [RATE_W-1:0]   max_bpm_cfg = MAX_BPM_RST;

   // Predictor state.
   logic [PEAK_W-1:0] peak_level    = '0;
   logic              in_peak       = 1'b0;
   logic [TIME_W-1:0] interval_ms   = '0;
   logic [TIME_W-1:0] since_beat_ms = '0;
   logic [RATE_W-1:0] rate_hist [HIST_DEPTH] = '{default: '0};
   int unsigned       filled        = 0;
   logic [RATE_W-1:0] mean_rate     = '0;

   logic [SAMPLE_W-1:0] sample_queue [$];
   beat_outcome_type    pending_outcomes [$];

   int unsigned sender_idle_pct    = 0;
   int unsigned receiver_stall_pct = 0;
   int unsigned rsp_hold_left      = 0;
   int unsigned cycle_count        = 0;
   int unsigned mismatch_count     = 0;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   task automatic report_mismatch(input string msg);
      if (mismatch_count < REPORT_CAP)
         $display("cycle %0d: %s", cycle_count, msg);
      mismatch_count++;
   endtask

   // Advances the tracker by one sample tick and queues the response it owes.
   function automatic void predict_beat_outcome(input logic [SAMPLE_W-1:0] sample);
      int unsigned      per, scale, hyst, v, pk, rate, sum, since, ival;
      beat_outcome_type res;
      per   = (period_cfg == 0) ? 1 : period_cfg;
      scale = 1000 / per;
      hyst  = 3000 / per;
      v     = sample * scale;
      pk    = peak_level;
      res.beat     = 1'b0;
      res.accepted = 1'b0;
      res.cleared  = 1'b0;

      if (v * 4 < pk)
         pk = (v * 4) / 5;
      if (v + scale > pk) begin
         if (v > pk)
            pk = v;
         res.beat = !in_peak;
         in_peak  = 1'b1;
      end else if (v + hyst < pk) begin
         in_peak = 1'b0;
         pk      = pk - scale;
      end
      peak_level = PEAK_W'(pk);

      if (res.beat) begin
         if (interval_ms != 0) begin
            rate = 60000 / interval_ms;
            if (rate >= min_bpm_cfg && rate <= max_bpm_cfg) begin
               for (int i = HIST_DEPTH - 1; i > 0; i--)
                  rate_hist[i] = rate_hist[i-1];
               rate_hist[0] = RATE_W'(rate);
               sum = 0;
               for (int i = 0; i < HIST_DEPTH; i++)
                  sum += rate_hist[i];
               if (filled < HIST_DEPTH)
                  filled++;
               mean_rate    = RATE_W'(sum / filled);
               res.accepted = 1'b1;
            end
         end
         interval_ms   = '0;
         since_beat_ms = '0;
      end else begin
         since = since_beat_ms + per;
         since_beat_ms = (since > 16'hFFFF) ? 16'hFFFF : TIME_W'(since);
         if (since_beat_ms > timeout_cfg) begin
            rate_hist   = '{default: '0};
            filled      = 0;
            mean_rate   = '0;
            res.cleared = 1'b1;
         end
      end
      ival = interval_ms + per;
      interval_ms = (ival > 16'hFFFF) ? 16'hFFFF : TIME_W'(ival);

      res.average = mean_rate;
      pending_outcomes.push_back(res);
   endfunction

   // Request driver: predicts on every accepted request, then offers the next.
   always @(posedge clock) begin
      if (reset) begin
         req_if.valid      <= 1'b0;
         req_if.adc_sample <= '0;
      end else begin
         if (req_if.valid && req_if.ready)
            predict_beat_outcome(req_if.adc_sample);
         if (!req_if.valid || req_if.ready) begin
            if (sample_queue.size() != 0 && $urandom_range(99) >= sender_idle_pct) begin
               req_if.valid      <= 1'b1;
               req_if.adc_sample <= sample_queue.pop_front();
            end else begin
               req_if.valid <= 1'b0;
            end
         end
      end
   end

   // Response monitor.
   always @(posedge clock) begin
      beat_outcome_type want;
      if (reset) begin
         rsp_if.ready <= 1'b0;
      end else begin
         if (rsp_if.valid && rsp_if.ready) begin
            if (pending_outcomes.size() == 0) begin
               report_mismatch("response with no request outstanding");
            end else begin
               want = pending_outcomes.pop_front();
               if (rsp_if.beat_detected !== want.beat)
                  report_mismatch($sformatf("beat_detected %b, expected %b",
                                  rsp_if.beat_detected, want.beat));
               if (rsp_if.new_bpm_accepted !== want.accepted)
                  report_mismatch($sformatf("new_bpm_accepted %b, expected %b",
                                  rsp_if.new_bpm_accepted, want.accepted));
               if (rsp_if.average_bpm !== want.average)
                  report_mismatch($sformatf("average_bpm %0d, expected %0d",
                                  rsp_if.average_bpm, want.average));
               if (rsp_if.history_cleared !== want.cleared)
                  report_mismatch($sformatf("history_cleared %b, expected %b",
                                  rsp_if.history_cleared, want.cleared));
            end
         end
         rsp_if.ready <= (rsp_hold_left == 0) && ($urandom_range(99) >= receiver_stall_pct);
      end
   end

   // Long receiver hold-off, counted down here once armed.
   always @(posedge clock) begin
      if (rsp_hold_left != 0)
         rsp_hold_left <= rsp_hold_left - 1;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("Mismatches found");
         $finish;
      end
   end

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input int unsigned value);
      @(posedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= CSR_DAT_W'(value);
      @(posedge clock);
      csr_we    <= 1'b0;
      case (idx)
         CSR_PERIOD:  period_cfg  = PERIOD_W'(value);
         CSR_TIMEOUT: timeout_cfg = TIME_W'(value);
         CSR_MIN_BPM: min_bpm_cfg = RATE_W'(value);
         CSR_MAX_BPM: max_bpm_cfg = RATE_W'(value);
         default: ;
      endcase
   endtask

   task automatic wait_idle;
      do
         @(negedge clock);
      while (sample_queue.size() != 0 || req_if.valid || pending_outcomes.size() != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // One pulse: a quick rise from a baseline to a crest, then a linear fall.
   task automatic add_pulse(input int unsigned min_len, input int unsigned max_len);
      int unsigned len, rise, hi, lo;
      int          s;
      len  = $urandom_range(max_len, min_len);
      rise = $urandom_range((len - 1 < 3) ? len - 1 : 3, 1);
      hi   = $urandom_range(1023, 200);
      lo   = $urandom_range(hi - 100, 0);
      for (int k = 0; k < len; k++) begin
         if (k < rise)
            s = lo + (hi - lo) * (k + 1) / rise;
         else
            s = hi - (hi - lo) * (k - rise + 1) / (len - rise);
         s = s + int'($urandom_range(12)) - 6;
         if (s < 0)
            s = 0;
         if (s > 1023)
            s = 1023;
         sample_queue.push_back(SAMPLE_W'(s));
      end
   endtask

   // Mostly pulse trains, with bursts of noise and flat stretches that
   // starve the detector long enough to reach the timeout.
   task automatic add_random_mix(input int unsigned budget,
                                 input int unsigned min_len, input int unsigned max_len);
      int unsigned added, start_size, pick, n, level;
      added = 0;
      while (added < budget) begin
         start_size = sample_queue.size();
         pick = $urandom_range(99);
         if (pick < 70) begin
            add_pulse(min_len, max_len);
         end else if (pick < 85) begin
            n = $urandom_range(8, 1);
            repeat (n) sample_queue.push_back(SAMPLE_W'($urandom_range(1023)));
         end else begin
            n     = $urandom_range(40, 5);
            level = $urandom_range(1023);
            repeat (n) sample_queue.push_back(SAMPLE_W'(level));
         end
         added += sample_queue.size() - start_size;
      end
   endtask

   task automatic run_phase(input int unsigned period, input int unsigned timeout,
                            input int unsigned min_bpm, input int unsigned max_bpm,
                            input int unsigned min_len, input int unsigned max_len,
                            input int unsigned send_pct, input int unsigned recv_pct,
                            input int unsigned hold);
      write_reg(CSR_PERIOD, period);
      write_reg(CSR_TIMEOUT, timeout);
      write_reg(CSR_MIN_BPM, min_bpm);
      write_reg(CSR_MAX_BPM, max_bpm);
      sender_idle_pct    = send_pct;
      receiver_stall_pct = recv_pct;
      add_random_mix(PHASE_ITEMS, min_len, max_len);
      if (hold != 0) begin
         @(negedge clock);
         rsp_hold_left = hold;
      end
      wait_idle();
   endtask

   initial begin
      int unsigned directed [] = '{0, 1023, 1023, 800, 600, 500, 1023, 800, 600, 480,
                                   400, 320, 1023, 512, 256, 1, 2, 4, 8, 16, 32, 64,
                                   128, 1023, 0};
      reset             = 1'b1;
      csr_we            = 1'b0;
      csr_index         = '0;
      csr_wdata         = '0;
      req_if.valid      = 1'b0;
      req_if.adc_sample = '0;
      rsp_if.ready      = 1'b0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // Directed samples at the reset settings; the very first request is a
      // beat with no interval behind it, so no rate may be produced.
      foreach (directed[i])
         sample_queue.push_back(SAMPLE_W'(directed[i]));
      wait_idle();

      //        period timeout  min  max  len      send recv hold
      run_phase(60,    2000,    40,  200, 6,  24,  80,  0,   0);
      run_phase(60,    7000,    40,  200, 6,  24,  0,   0,   400);
      run_phase(0,     500,     0,   255, 2,  10,  0,   80,  0);
      run_phase(1023,  65535,   0,   255, 3,  10,  14,  14,  0);
      run_phase(1000,  0,       0,   255, 2,  6,   80,  0,   0);
      run_phase(250,   3000,    200, 40,  2,  8,   0,   80,  0);
      run_phase(20,    65535,   0,   255, 10, 40,  0,   0,   0);
      run_phase(100,   1500,    60,  150, 4,  12,  14,  14,  0);
      run_phase(47,    1000,    255, 255, 4,  6,   0,   0,   0);

      if (mismatch_count == 0)
         $display("No mismatches found");
      else
         $display("Mismatches found");
      $finish;
   end

endmodule

// File: files.f
hdl/ppba_pkg.sv
hdl/ppba_if.sv
hdl/ppba_div.sv
hdl/pulse_peak_bpm_averager.sv
hdl/ppba_checker.sv
tb/tb_pulse_peak_bpm_averager.sv
